// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// implication after the delay given by dly
`define ASSERT_DLY(name, clk, rst_n, ante, dly, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbps_pkg;

    // audio setup
    localparam int SAMPLE_RATE     = 48000;
    localparam int NUM_PARTIALS    = 4;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PART_W          = $clog2(NUM_PARTIALS);

    // field widths
    localparam int PHASE_W  = 32;
    localparam int ENV_W    = 18;
    localparam int IDX_W    = 20;
    localparam int VOL_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int SINE_W   = 15;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 2'd2;
    localparam logic [VOL_W-1:0]     VOL_RESET     = 16'd16384;

    // envelope start value, 1.0 in q1.17
    localparam logic [ENV_W-1:0] ENV_ONE = 18'h20000;

    // attack ramp: 6 ms, or a tenth of the strike
    localparam int ATT_MAX     = 6 * SAMPLE_RATE / 1000;
    localparam int ATT_W       = $clog2(ATT_MAX + 1);
    localparam int ATT_LIM     = 10 * ATT_MAX;
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;
    localparam int QUO_W       = 16;
    localparam int GAIN_W      = QUO_W + 1;
    localparam logic [GAIN_W-1:0] ATT_ONE = 17'h10000;
    localparam int DIV_CNT_W   = $clog2(QUO_W + 1);
    localparam int DIV_LAT     = QUO_W + 1;

    // shared bit-serial multiplier
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 19;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
    localparam int MUL_LAT   = MUL_B_W + 1;

    // output scaling
    localparam logic [MUL_B_W-1:0] SCALE_OUT = 19'd32000;
    localparam logic [SAMPLE_W-1:0] V_MAX    = 16'd32768;

    typedef logic [NUM_PARTIALS-1:0][MUL_B_W-1:0] t_coef;
    typedef logic [(1 << (SINE_TABLE_BITS - 2))-1:0][SINE_W-1:0] t_sine_tbl;

    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int QTR_LEN = 1 << QBITS;

    // partial frequency ratios q3.16 and amplitudes q3.16
    localparam t_coef RATIO_Q16  = {19'd355860, 19'd252969, 19'd157942, 19'd65536};
    localparam t_coef AMP_Q16    = {19'd13107, 19'd22938, 19'd36045, 19'd65536};
    localparam t_coef DECAY_RATE = {19'd13, 19'd9, 19'd6, 19'd3};

    // per-sample decay factor q1.17 from a cubic series of exp(-rate/fs)
    function automatic logic [ENV_W-1:0] decay_q17(input logic [63:0] rate);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] e;
        x  = (rate << 40) / SAMPLE_RATE;
        x2 = (x * x) >> 40;
        x3 = (x2 * x) >> 40;
        e  = (64'd1 << 40) - x + x2 / 2 - x3 / 6;
        e  = (e + (64'd1 << 22)) >> 23;
        return e[ENV_W-1:0];
    endfunction

    function automatic t_coef build_decay();
        t_coef tbl;
        for (int i = 0; i < NUM_PARTIALS; i++) begin
            tbl[i] = MUL_B_W'(decay_q17(64'(DECAY_RATE[i])));
        end
        return tbl;
    endfunction

    localparam t_coef DECAY_Q17 = build_decay();

    // quarter-wave sine entry, odd polynomial to x^9 in q30
    function automatic logic [SINE_W-1:0] sine_q(input logic [63:0] a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (a * 64'd6746518852) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        v  = (s + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

    function automatic t_sine_tbl build_sine();
        t_sine_tbl tbl;
        for (int i = 0; i < QTR_LEN; i++) begin
            tbl[i] = sine_q(64'(i));
        end
        return tbl;
    endfunction

    localparam t_sine_tbl         SINE_QTR  = build_sine();
    localparam logic [SINE_W-1:0] SINE_PEAK = sine_q(64'(QTR_LEN));

endpackage

`default_nettype wire

// ===== hdl/struck_bar_partial_synth_core.sv =====
// Struck-bar tone generator: each accepted input word yields one 16-bit signed sample
// built from four decaying inharmonic partials (sine table lookup, per-partial envelope,
// linear attack ramp, volume, clamp and scale to +-32000). restart=1 begins a strike at
// sample zero; once the strike duration is reached the word comes back with active low
// and a zero sample. The design is built around one shared bit-serial multiplier, which
// handles one multiplier bit per cycle and does 19 products per sample, four per partial
// and three for gain and scaling, plus one more on a restart word. The attack gain comes
// from a bit-serial divider, one quotient bit a cycle, while the attack ramp is running.
// The finished sample sits in an output register, so the next input word is taken while
// it waits. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module struck_bar_partial_synth_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sbps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sbps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_restart,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sbps_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                  o_last,
    output logic                                  o_active
);
    import sbps_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_ATT      = 4'd1;
    localparam logic [3:0] ST_CHECK    = 4'd2;
    localparam logic [3:0] ST_SIN      = 4'd3;
    localparam logic [3:0] ST_MUL_ME   = 4'd4;
    localparam logic [3:0] ST_MUL_AMP  = 4'd5;
    localparam logic [3:0] ST_MUL_STEP = 4'd6;
    localparam logic [3:0] ST_MUL_ENV  = 4'd7;
    localparam logic [3:0] ST_GAIN     = 4'd8;
    localparam logic [3:0] ST_DIV      = 4'd9;
    localparam logic [3:0] ST_MUL_MA   = 4'd10;
    localparam logic [3:0] ST_MUL_MV   = 4'd11;
    localparam logic [3:0] ST_MUL_SC   = 4'd12;
    localparam logic [3:0] ST_FIN      = 4'd13;

    // datapath widths and product bit positions
    localparam int SUM_W     = 18;
    localparam int TERM_W    = 16;
    localparam int TERM_LSB  = 33;
    localparam int STEP_LSB  = 16;
    localparam int ENV_LSB   = 17;
    localparam int VRAW_LSB  = 31;
    localparam int VRAW_W    = 19;
    localparam int RES_LSB   = 15;

    // configuration registers
    logic [PHASE_W-1:0] r_base;
    logic [IDX_W-1:0]   r_duration;
    logic [VOL_W-1:0]   r_volume;

    // control and strike state
    logic [3:0]         r_state, n_state;
    logic [PART_W-1:0]  r_part, n_part;
    logic               r_launch, n_launch;
    logic [IDX_W-1:0]   r_index, n_index;
    logic [ATT_W-1:0]   r_att_len, n_att_len;
    logic [PHASE_W-1:0] r_phase [NUM_PARTIALS];
    logic [PHASE_W-1:0] n_phase [NUM_PARTIALS];
    logic [ENV_W-1:0]   r_env [NUM_PARTIALS];
    logic [ENV_W-1:0]   n_env [NUM_PARTIALS];
    logic               r_out_valid;

    // datapath registers
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [MUL_A_W-1:0]  r_tmp, n_tmp;
    logic [GAIN_W-1:0]   r_att, n_att;
    logic [SINE_W-1:0]   r_sin_mag, n_sin_mag;
    logic                r_sin_neg, n_sin_neg;
    logic [SAMPLE_W-1:0] r_res_sample, n_res_sample;
    logic                r_res_last, n_res_last;
    logic                r_res_active, n_res_active;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_last;
    logic                r_out_active;

    // unit connections
    logic               w_mul_done;
    logic [MUL_P_W-1:0] w_prod;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic               w_div_done;
    logic [QUO_W-1:0]   w_quo;

    // derived values
    logic [IDX_W-1:0]           w_dur;
    logic [PHASE_W-1:0]         w_phase_cur;
    logic [SINE_TABLE_BITS-1:0] w_sin_k;
    logic [1:0]                 w_sin_quad;
    logic [QBITS-1:0]           w_sin_r;
    logic [QBITS-1:0]           w_sin_rn;
    logic [SINE_W-1:0]          w_sin_mag;
    logic [TERM_W-1:0]          w_term;
    logic [SUM_W-1:0]           w_mag;
    logic [VRAW_W-1:0]          w_vraw;
    logic [SAMPLE_W-1:0]        w_res;
    logic                       w_out_free;
    logic                       w_is_unit;

    assign w_dur       = (r_duration == '0) ? IDX_W'(1) : r_duration;
    assign w_out_free  = !r_out_valid || i_ready;
    assign o_ready     = (r_state == ST_IDLE);

    // sine lookup, quarter table mirrored by phase quadrant
    assign w_phase_cur = r_phase[r_part];
    assign w_sin_k     = w_phase_cur[PHASE_W-1 -: SINE_TABLE_BITS];
    assign w_sin_quad  = w_sin_k[SINE_TABLE_BITS-1 -: 2];
    assign w_sin_r     = w_sin_k[QBITS-1:0];
    assign w_sin_rn    = QBITS'(0) - w_sin_r;
    assign w_sin_mag   = !w_sin_quad[0] ? SINE_QTR[w_sin_r] :
                         (w_sin_r == '0) ? SINE_PEAK : SINE_QTR[w_sin_rn];

    // product slices
    assign w_term = w_prod[TERM_LSB +: TERM_W];
    assign w_mag  = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_vraw = w_prod[VRAW_LSB +: VRAW_W];
    assign w_res  = w_prod[RES_LSB +: SAMPLE_W];

    // multiplier operand select
    always_comb begin
        case (r_state)
            ST_ATT: begin
                w_mul_a = MUL_A_W'(w_dur);
                w_mul_b = MUL_B_W'(DIV10_MUL);
            end
            ST_MUL_ME: begin
                w_mul_a = MUL_A_W'(r_env[r_part]);
                w_mul_b = MUL_B_W'(r_sin_mag);
            end
            ST_MUL_AMP: begin
                w_mul_a = r_tmp;
                w_mul_b = AMP_Q16[r_part];
            end
            ST_MUL_STEP: begin
                w_mul_a = MUL_A_W'(r_base);
                w_mul_b = RATIO_Q16[r_part];
            end
            ST_MUL_ENV: begin
                w_mul_a = MUL_A_W'(r_env[r_part]);
                w_mul_b = DECAY_Q17[r_part];
            end
            ST_MUL_MA: begin
                w_mul_a = MUL_A_W'(w_mag);
                w_mul_b = MUL_B_W'(r_att);
            end
            ST_MUL_MV: begin
                w_mul_a = r_tmp;
                w_mul_b = MUL_B_W'(r_volume);
            end
            ST_MUL_SC: begin
                w_mul_a = r_tmp;
                w_mul_b = SCALE_OUT;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_part       = r_part;
        n_index      = r_index;
        n_att_len    = r_att_len;
        n_phase      = r_phase;
        n_env        = r_env;
        n_sum        = r_sum;
        n_tmp        = r_tmp;
        n_att        = r_att;
        n_sin_mag    = r_sin_mag;
        n_sin_neg    = r_sin_neg;
        n_res_sample = r_res_sample;
        n_res_last   = r_res_last;
        n_res_active = r_res_active;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_restart ? ST_ATT : ST_CHECK;
                end
            end
            // restart: attack length = min(6 ms, duration / 10), fresh partials
            ST_ATT: begin
                if (w_mul_done) begin
                    n_att_len = (w_dur >= IDX_W'(ATT_LIM)) ? ATT_W'(ATT_MAX) :
                                w_prod[DIV10_SHIFT +: ATT_W];
                    n_index   = '0;
                    for (int p = 0; p < NUM_PARTIALS; p++) begin
                        n_phase[p] = '0;
                        n_env[p]   = ENV_ONE;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_sum  = '0;
                n_part = '0;
                if (r_index >= w_dur) begin
                    n_res_sample = '0;
                    n_res_last   = 1'b0;
                    n_res_active = 1'b0;
                    n_state      = ST_FIN;
                end else begin
                    n_state = ST_SIN;
                end
            end
            ST_SIN: begin
                n_sin_mag = w_sin_mag;
                n_sin_neg = w_sin_quad[1];
                n_state   = ST_MUL_ME;
            end
            ST_MUL_ME: begin
                if (w_mul_done) begin
                    n_tmp   = w_prod[MUL_A_W-1:0];
                    n_state = ST_MUL_AMP;
                end
            end
            ST_MUL_AMP: begin
                if (w_mul_done) begin
                    n_sum   = r_sin_neg ? (r_sum - SUM_W'(w_term)) : (r_sum + SUM_W'(w_term));
                    n_state = ST_MUL_STEP;
                end
            end
            ST_MUL_STEP: begin
                if (w_mul_done) begin
                    n_phase[r_part] = r_phase[r_part] + w_prod[STEP_LSB +: PHASE_W];
                    n_state         = ST_MUL_ENV;
                end
            end
            ST_MUL_ENV: begin
                if (w_mul_done) begin
                    n_env[r_part] = w_prod[ENV_LSB +: ENV_W];
                    if (r_part == PART_W'(NUM_PARTIALS - 1)) begin
                        n_state = ST_GAIN;
                    end else begin
                        n_part  = r_part + PART_W'(1);
                        n_state = ST_SIN;
                    end
                end
            end
            // full gain outside the attack ramp
            ST_GAIN: begin
                if ((r_att_len == '0) || (r_index >= IDX_W'(r_att_len))) begin
                    n_att   = ATT_ONE;
                    n_state = ST_MUL_MA;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_att   = GAIN_W'(w_quo);
                    n_state = ST_MUL_MA;
                end
            end
            ST_MUL_MA: begin
                if (w_mul_done) begin
                    n_tmp   = w_prod[MUL_A_W-1:0];
                    n_state = ST_MUL_MV;
                end
            end
            // clamp to full scale
            ST_MUL_MV: begin
                if (w_mul_done) begin
                    n_tmp   = (w_vraw > VRAW_W'(V_MAX)) ? MUL_A_W'(V_MAX) : MUL_A_W'(w_vraw);
                    n_state = ST_MUL_SC;
                end
            end
            ST_MUL_SC: begin
                if (w_mul_done) begin
                    n_res_sample = r_sum[SUM_W-1] ? (SAMPLE_W'(0) - w_res) : w_res;
                    n_res_last   = (r_index == (w_dur - IDX_W'(1)));
                    n_res_active = 1'b1;
                    n_index      = r_index + IDX_W'(1);
                    n_state      = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // pulse a start on entry into a multiply or divide state
    assign w_is_unit = (n_state == ST_ATT) || (n_state == ST_MUL_ME) ||
                       (n_state == ST_MUL_AMP) || (n_state == ST_MUL_STEP) ||
                       (n_state == ST_MUL_ENV) || (n_state == ST_DIV) ||
                       (n_state == ST_MUL_MA) || (n_state == ST_MUL_MV) ||
                       (n_state == ST_MUL_SC);
    assign n_launch  = (n_state != r_state) && w_is_unit;

    // control and strike state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_part     <= '0;
            r_launch   <= 1'b0;
            r_index    <= '1;
            r_att_len  <= '0;
            r_base     <= '0;
            r_duration <= IDX_W'(1);
            r_volume   <= VOL_RESET;
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                r_phase[p] <= '0;
                r_env[p]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_part    <= n_part;
            r_launch  <= n_launch;
            r_index   <= n_index;
            r_att_len <= n_att_len;
            r_phase   <= n_phase;
            r_env     <= n_env;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_STEP: r_base     <= i_cfg_data[PHASE_W-1:0];
                    CFG_DURATION:  r_duration <= i_cfg_data[IDX_W-1:0];
                    CFG_VOLUME:    r_volume   <= i_cfg_data[VOL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sum        <= n_sum;
        r_tmp        <= n_tmp;
        r_att        <= n_att;
        r_sin_mag    <= n_sin_mag;
        r_sin_neg    <= n_sin_neg;
        r_res_sample <= n_res_sample;
        r_res_last   <= n_res_last;
        r_res_active <= n_res_active;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_sample <= r_res_sample;
            r_out_last   <= r_res_last;
            r_out_active <= r_res_active;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_last   = r_out_last;
    assign o_active = r_out_active;

    // shared units
    sbps_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_launch && (r_state != ST_DIV)),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    sbps_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_launch && (r_state == ST_DIV)),
        .i_num   (r_index[ATT_W-1:0]),
        .i_den   (r_att_len),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    `ASSERT_IMP(a_inactive_zero, i_clk, i_rst_n, o_valid && !o_active, (o_sample == '0) && !o_last, "inactive word with data")
    `ASSERT_IMP(a_mul_done_state, i_clk, i_rst_n, w_mul_done, (r_state == ST_ATT) || (r_state == ST_MUL_ME) || (r_state == ST_MUL_AMP) || (r_state == ST_MUL_STEP) || (r_state == ST_MUL_ENV) || (r_state == ST_MUL_MA) || (r_state == ST_MUL_MV) || (r_state == ST_MUL_SC), "product outside a multiply state")
    `ASSERT_NXT(a_fin_load, i_clk, i_rst_n, (r_state == ST_FIN) && w_out_free, o_valid && (r_state == ST_IDLE), "result not loaded")

endmodule

`default_nettype wire

// ===== hdl/sbps_smul.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbps_smul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sbps_pkg::MUL_A_W-1:0] i_a,
    input  logic [sbps_pkg::MUL_B_W-1:0] i_b,
    output logic                         o_done,
    output logic [sbps_pkg::MUL_P_W-1:0] o_prod
);
    import sbps_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_P_W-1:0]   r_p;
    logic [MUL_A_W:0]     w_add;

    // add the multiplicand on the low multiplier bit, then shift right
    assign w_add = {1'b0, r_p[MUL_P_W-1:MUL_B_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == MUL_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operand and product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MUL_A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_add, r_p[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

    `ASSERT_DLY(a_mul_latency, i_clk, i_rst_n, i_start, MUL_LAT, o_done, "product late")
    `ASSERT_IMP(a_mul_no_restart, i_clk, i_rst_n, i_start, !r_busy, "start while busy")
    `ASSERT_IMP(a_mul_done_idle, i_clk, i_rst_n, o_done, !r_busy, "done while busy")

endmodule

`default_nettype wire

// ===== hdl/sbps_sdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbps_sdiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sbps_pkg::ATT_W-1:0] i_num,
    input  logic [sbps_pkg::ATT_W-1:0] i_den,
    output logic                       o_done,
    output logic [sbps_pkg::QUO_W-1:0] o_quo
);
    import sbps_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ATT_W-1:0]     r_rem;
    logic [ATT_W-1:0]     r_den;
    logic [QUO_W-1:0]     r_quo;
    logic [ATT_W:0]       w_shift;
    logic [ATT_W:0]       w_diff;
    logic                 w_ge;

    // one quotient bit per cycle, numerator below divisor so only fraction bits remain
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ATT_W-1:0] : w_shift[ATT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    `ASSERT_DLY(a_div_latency, i_clk, i_rst_n, i_start, DIV_LAT, o_done, "quotient late")
    `ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_busy, r_rem < r_den, "remainder overflow")
    `ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, i_start, !r_busy, "start while busy")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import sbps_pkg::*;

    // run shape
    localparam int TOTAL_WORDS    = 1800;
    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 2500;
    localparam int QUIET_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int REPORT_LIMIT   = 10;
    localparam int CALM_PHASE     = 4;

    // unused register slot, writes there must not disturb anything
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // tone recipe, per partial
    localparam logic [3:0][18:0] PARTIAL_RATIO = {19'd355860, 19'd252969, 19'd157942, 19'd65536};
    localparam logic [3:0][16:0] PARTIAL_AMP   = {17'd13107, 17'd22938, 17'd36045, 17'd65536};
    localparam logic [3:0][7:0]  PARTIAL_DECAY = {8'd13, 8'd9, 8'd6, 8'd3};
    localparam logic [3:0][7:0]  SERIES_DIV    = {8'd6, 8'd20, 8'd42, 8'd72};
    localparam int WAVE_QTR    = 1 << (SINE_TABLE_BITS - 2);
    localparam int ATTACK_CAP  = 6 * SAMPLE_RATE / 1000;
    localparam int FULL_SCALE  = 32000;

    typedef struct packed {
        logic signed [15:0] level;
        logic               is_last;
        logic               is_active;
    } synth_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_restart;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [15:0]    o_sample;
    logic                  o_last;
    logic                  o_active;

    // shadow of the voice registers and the tone state
    logic [31:0] step_reg;
    logic [19:0] dur_reg;
    logic [15:0] vol_reg;
    logic [19:0] tone_idx;
    logic [19:0] attack_len;
    logic [31:0] phase_acc [NUM_PARTIALS];
    logic [17:0] env_lvl [NUM_PARTIALS];
    logic [63:0] decay_q17 [NUM_PARTIALS];
    logic [15:0] wave_mag [0:WAVE_QTR];

    synth_word_t pending_samples [$];
    synth_word_t want;

    // bookkeeping
    bit sender_idles;
    bit recv_idles;
    int hold_reqs;
    int holds_served;
    int quiet_cycles;
    int words_sent;
    int samples_checked;
    int active_seen;
    int strike_ends;
    int reg_writes;
    int fail_count;
    int reported;

    struck_bar_partial_synth_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_restart  (i_restart),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_sample   (o_sample),
        .o_last     (o_last),
        .o_active   (o_active)
    );

    always #6 i_clk = ~i_clk;

    // quarter-wave magnitudes and per-sample decay factors
    initial begin : build_tables
        logic [63:0] arg;
        logic [63:0] sq;
        logic [63:0] poly;
        logic [63:0] mag;
        logic [63:0] x1;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] e;
        for (int a = 0; a <= WAVE_QTR; a++) begin
            arg  = (64'(a) * 64'd6746518852) >> SINE_TABLE_BITS;
            sq   = (arg * arg) >> 30;
            poly = 64'd1 << 30;
            for (int i = 0; i < 4; i++) begin
                poly = (64'd1 << 30) - ((sq * poly) >> 30) / 64'(SERIES_DIV[i]);
            end
            mag = (((arg * poly) >> 30) + 64'd16384) >> 15;
            wave_mag[a] = (mag > 64'd32767) ? 16'd32767 : mag[15:0];
        end
        for (int p = 0; p < NUM_PARTIALS; p++) begin
            x1 = (64'(PARTIAL_DECAY[p]) << 40) / 64'(SAMPLE_RATE);
            x2 = (x1 * x1) >> 40;
            x3 = (x2 * x1) >> 40;
            e  = (64'd1 << 40) - x1 + x2 / 2 - x3 / 6;
            decay_q17[p] = (e + (64'd1 << 22)) >> 23;
        end
    end

    // next sample of the tone, pushed as the expected output word
    task automatic predict_sample(input bit restart);
        int unsigned dur_eff;
        int unsigned k;
        int unsigned quad;
        int unsigned r;
        int unsigned a;
        logic [63:0] m;
        logic [63:0] term;
        logic [63:0] gain;
        logic [63:0] mag;
        logic [63:0] lvl;
        logic [63:0] scaled;
        longint      sum;
        synth_word_t w;
        dur_eff = (dur_reg == 20'd0) ? 1 : dur_reg;
        if (restart) begin
            attack_len = (ATTACK_CAP < dur_eff / 10) ? 20'(ATTACK_CAP) : 20'(dur_eff / 10);
            tone_idx   = '0;
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                phase_acc[p] = '0;
                env_lvl[p]   = 18'h20000;
            end
        end
        w = '0;
        if (tone_idx < dur_eff) begin
            sum = 0;
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                k    = phase_acc[p][31 -: SINE_TABLE_BITS];
                quad = k >> (SINE_TABLE_BITS - 2);
                r    = k & (WAVE_QTR - 1);
                a    = quad[0] ? WAVE_QTR - r : r;
                m    = 64'(wave_mag[a]);
                term = (m * 64'(env_lvl[p]) * 64'(PARTIAL_AMP[p])) >> 33;
                sum  = (quad >= 2) ? sum - longint'(term) : sum + longint'(term);
            end
            if (attack_len == 20'd0 || tone_idx >= attack_len) begin
                gain = 64'd65536;
            end else begin
                gain = (64'(tone_idx) << 16) / 64'(attack_len);
            end
            mag    = (sum < 0) ? 64'(-sum) : 64'(sum);
            lvl    = (mag * gain * 64'(vol_reg)) >> 31;
            lvl    = (lvl > 64'd32768) ? 64'd32768 : lvl;
            scaled = (lvl * 64'(FULL_SCALE)) >> 15;
            w.level     = (sum < 0) ? 16'(64'd0 - scaled) : 16'(scaled);
            w.is_last   = (tone_idx == 20'(dur_eff - 1));
            w.is_active = 1'b1;
            // advance phases and envelopes for the next sample
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                phase_acc[p] = phase_acc[p]
                             + 32'((64'(step_reg) * 64'(PARTIAL_RATIO[p])) >> 16);
                env_lvl[p]   = 18'((64'(env_lvl[p]) * decay_q17[p]) >> 17);
            end
            tone_idx = tone_idx + 20'd1;
        end
        pending_samples.push_back(w);
    endtask

    // offer one input word, with random idle cycles ahead of it
    task automatic send_word(input bit restart);
        while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_sample(restart);
        words_sent++;
    endtask

    task automatic strike(input int ticks);
        send_word(1'b1);
        repeat (ticks) send_word(1'b0);
    endtask

    // stop offering and let every expected sample come out
    task automatic wait_for_samples();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
    endtask

    // write the three voice registers back to back, upper data bits random, then optionally the unused slot
    task automatic apply_regs(input logic [31:0] step, input logic [19:0] dur,
                              input logic [15:0] vol, input bit poke_unused);
        logic [31:0] junk;
        junk = $urandom();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE_STEP;
        i_cfg_data <= step;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DURATION;
        i_cfg_data <= {junk[31:20], dur};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_VOLUME;
        i_cfg_data <= {junk[31:16], vol};
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= $urandom();
            @(posedge i_clk);
            reg_writes++;
        end
        i_cfg_we <= 1'b0;
        step_reg = step;
        dur_reg  = dur;
        vol_reg  = vol;
        reg_writes += 3;
    endtask

    // ticks before any strike, then a one-sample strike on reset registers
    task automatic test_power_on_silence();
        send_word(1'b0);
        send_word(1'b0);
        strike(1);
    endtask

    // duration zero behaves as a single sample
    task automatic test_zero_duration();
        wait_for_samples();
        apply_regs(32'hFFFF_FFFF, 20'd0, 16'hFFFF, 1'b1);
        strike(2);
    endtask

    // quarter-cycle step at full volume drives the clamp
    task automatic test_clamp_extremes();
        wait_for_samples();
        apply_regs(32'h4000_0000, 20'd6, 16'hFFFF, 1'b0);
        strike(6);
    endtask

    // shrink duration under a running strike, then grow it back
    task automatic test_mid_strike_registers();
        wait_for_samples();
        apply_regs(32'h0C00_0000, 20'd40, 16'd0, 1'b0);
        strike(2);
        wait_for_samples();
        apply_regs(32'h1234_5678, 20'd2, 16'd30000, 1'b0);
        send_word(1'b0);
        wait_for_samples();
        apply_regs(32'h8000_0000, 20'd40, 16'd16384, 1'b0);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
    endtask

    // long output stall while words keep coming, longest duration
    task automatic test_output_backpressure();
        wait_for_samples();
        apply_regs(32'h0100_0000, 20'hFFFFF, 16'd20000, 1'b0);
        hold_reqs <= hold_reqs + 1;
        strike(11);
        wait_for_samples();
    endtask

    // random voices, strikes of random length with stray words between
    task automatic test_random_strikes();
        int          phase_no;
        int          phase_len;
        int          phase_start;
        int          sel;
        int unsigned dur_eff;
        int unsigned cap;
        logic [31:0] step;
        logic [19:0] dur;
        logic [15:0] vol;
        phase_no = 0;
        while (words_sent < TOTAL_WORDS) begin
            phase_no++;
            sender_idles = (phase_no != CALM_PHASE);
            recv_idles   = (phase_no != CALM_PHASE);
            sel = $urandom_range(0, 99);
            if (sel < 40)      step = $urandom();
            else if (sel < 75) step = $urandom_range(0, 32'h0400_0000);
            else if (sel < 85) step = 32'd0;
            else if (sel < 95) step = 32'hFFFF_FFFF;
            else               step = $urandom() & 32'hC000_0000;
            sel = $urandom_range(0, 99);
            if (sel < 60)      dur = $urandom_range(1, 40);
            else if (sel < 80) dur = $urandom_range(41, 400);
            else if (sel < 92) dur = $urandom_range(2880, 3600);
            else if (sel < 96) dur = 20'd0;
            else               dur = $urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom());
            sel = $urandom_range(0, 99);
            if (sel < 35)      vol = $urandom_range(0, 65535);
            else if (sel < 65) vol = $urandom_range(12000, 20000);
            else if (sel < 80) vol = $urandom_range(0, 2000);
            else if (sel < 90) vol = 16'hFFFF;
            else               vol = 16'd0;
            apply_regs(step, dur, vol, $urandom_range(0, 7) == 0);
            phase_len   = $urandom_range(60, 160);
            phase_start = words_sent;
            while (words_sent - phase_start < phase_len && words_sent < TOTAL_WORDS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word($urandom_range(0, 1));
                end else begin
                    dur_eff = (dur_reg == 20'd0) ? 1 : dur_reg;
                    cap     = (dur_eff > 300) ? 300 : dur_eff + 3;
                    strike($urandom_range(0, cap));
                end
            end
            wait_for_samples();
        end
        sender_idles = 1'b1;
        recv_idles   = 1'b1;
    endtask

    // receiver: random stalls, plus a long hold when asked
    initial begin
        i_ready      = 1'b0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_served) begin
                holds_served++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (recv_idles && $urandom_range(0, 99) < IDLE_PCT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // compare each output word with the oldest expected sample
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                fail_count++;
                if (reported < REPORT_LIMIT) begin
                    $display("%0t unexpected output word: sample %0d last %0b active %0b",
                             $time, o_sample, o_last, o_active);
                end
                reported++;
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                active_seen += want.is_active;
                strike_ends += want.is_last;
                if (o_sample !== want.level || o_last !== want.is_last
                        || o_active !== want.is_active) begin
                    fail_count++;
                    if (reported < REPORT_LIMIT) begin
                        $display("%0t sample mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 $time, $signed(want.level), want.is_last, want.is_active,
                                 o_sample, o_last, o_active);
                    end
                    reported++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("struck_bar_partial_synth_core verification failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_BASE_STEP;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_restart    = 1'b0;
        sender_idles = 1'b1;
        recv_idles   = 1'b1;
        hold_reqs    = 0;
        quiet_cycles = 0;
        step_reg     = '0;
        dur_reg      = 20'd1;
        vol_reg      = VOL_RESET;
        tone_idx     = 20'hFFFFF;
        attack_len   = '0;
        for (int p = 0; p < NUM_PARTIALS; p++) begin
            phase_acc[p] = '0;
            env_lvl[p]   = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_silence();
        test_zero_duration();
        test_clamp_extremes();
        test_mid_strike_registers();
        test_output_backpressure();
        test_random_strikes();

        wait_for_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d input words and %0d register writes over many voices",
                 words_sent, reg_writes);
        $display("checked %0d samples: %0d in a strike, %0d strike ends, %0d errors",
                 samples_checked, active_seen, strike_ends, fail_count);
        if (fail_count == 0 && pending_samples.size() == 0) begin
            $display("struck_bar_partial_synth_core verification clean");
        end else begin
            $display("struck_bar_partial_synth_core verification failed");
        end
        $finish;
    end

endmodule
